@@ hdl/srlp_pkg.sv @@
// ----------------------------------------------------------------------------
// srlp_pkg - shared types and constants of the sensor record line parser
// Character codes, line positions, the per-position field kind, the decoded
// character word and the record word.
// ----------------------------------------------------------------------------
package srlp_pkg;

   // Character codes
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UC_A    = 8'h41;
   localparam logic [7:0] CHAR_UC_F    = 8'h46;
   localparam logic [7:0] CHAR_LC_A    = 8'h61;
   localparam logic [7:0] CHAR_LC_F    = 8'h66;
   // letters a-f / A-F have low nibble 1..6, so value = nibble + 9
   localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

   // Field widths
   localparam int POS_W   = 5;
   localparam int YEAR_W  = 14;
   localparam int PAIR_W  = 7;
   localparam int BATT_W  = 13;
   localparam int TENTH_W = 16;
   localparam int SLOTS   = 5;
   localparam int SLOT_W  = 3;

   // Line positions
   localparam logic [POS_W-1:0] POS_YEAR_SEP  = 5'd4;
   localparam logic [POS_W-1:0] POS_HEX_START = 5'd20;
   localparam logic [POS_W-1:0] POS_BATT_LO   = 5'd21;
   localparam logic [POS_W-1:0] POS_TEMP_HI   = 5'd23;
   localparam logic [POS_W-1:0] POS_TEMP_LO   = 5'd25;
   localparam logic [POS_W-1:0] POS_HUM_HI    = 5'd27;
   localparam logic [POS_W-1:0] POS_HUM_LO    = 5'd29;
   localparam logic [POS_W-1:0] POS_MONTH_HI  = 5'd5;
   localparam logic [POS_W-1:0] POS_MONTH_LO  = 5'd6;
   localparam logic [POS_W-1:0] POS_DAY_HI    = 5'd8;
   localparam logic [POS_W-1:0] POS_DAY_LO    = 5'd9;
   localparam logic [POS_W-1:0] POS_HOUR_HI   = 5'd11;
   localparam logic [POS_W-1:0] POS_HOUR_LO   = 5'd12;
   localparam logic [POS_W-1:0] POS_MIN_HI    = 5'd14;
   localparam logic [POS_W-1:0] POS_MIN_LO    = 5'd15;
   localparam logic [POS_W-1:0] POS_SEC_HI    = 5'd17;
   localparam logic [POS_W-1:0] POS_SEC_LO    = 5'd18;

   // Slot indexes of the date/time fields
   localparam logic [SLOT_W-1:0] SLOT_MONTH  = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_DAY    = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_HOUR   = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_MINUTE = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_SECOND = 3'd4;

   typedef enum logic [2:0] {
      KIND_YEAR,
      KIND_SKIP,
      KIND_PAIR_HI,
      KIND_PAIR_LO,
      KIND_HEX_HI,
      KIND_HEX_LO
   } pos_kind_type;

   // Decoded character
   typedef struct packed {
      logic       newline;
      logic       dec_ok;
      logic [3:0] dec_val;   // zero when not a decimal digit
      logic       hex_ok;
      logic [3:0] hex_val;   // zero when not a hex digit
   } char_info_type;

   // Line state status towards the top level
   typedef struct packed {
      logic             emit;      // word in hand completes a record
      logic [POS_W-1:0] position;
   } line_status_type;

   // One parsed record
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [PAIR_W-1:0]  month;
      logic [PAIR_W-1:0]  day;
      logic [PAIR_W-1:0]  hour;
      logic [PAIR_W-1:0]  minute;
      logic [PAIR_W-1:0]  second;
      logic [BATT_W-1:0]  battery_level;
      logic [TENTH_W-1:0] temperature_tenths;
      logic [TENTH_W-1:0] humidity_tenths;
      logic               format_error;
   } record_type;

   // What a line position holds
   function automatic pos_kind_type pos_kind(input logic [POS_W-1:0] pos);
      pos_kind_type k;
      if (pos < POS_YEAR_SEP) begin
         k = KIND_YEAR;
      end else if (pos == POS_YEAR_SEP) begin
         k = KIND_SKIP;
      end else if (pos < POS_HEX_START) begin
         // within a date/time group: first digit, second digit, separator
         unique case (pos)
            POS_MONTH_HI, POS_DAY_HI, POS_HOUR_HI, POS_MIN_HI, POS_SEC_HI:
               k = KIND_PAIR_HI;
            POS_MONTH_LO, POS_DAY_LO, POS_HOUR_LO, POS_MIN_LO, POS_SEC_LO:
               k = KIND_PAIR_LO;
            default: k = KIND_SKIP;
         endcase
      end else if (pos <= POS_HUM_LO) begin
         k = pos[0] ? KIND_HEX_LO : KIND_HEX_HI;
      end else begin
         k = KIND_SKIP;
      end
      return k;
   endfunction

   // Date/time slot written at a second-digit position
   function automatic logic [SLOT_W-1:0] slot_of(input logic [POS_W-1:0] pos);
      logic [SLOT_W-1:0] s;
      priority if (pos < POS_DAY_LO) begin
         s = SLOT_MONTH;
      end else if (pos < POS_HOUR_LO) begin
         s = SLOT_DAY;
      end else if (pos < POS_MIN_LO) begin
         s = SLOT_HOUR;
      end else if (pos < POS_SEC_LO) begin
         s = SLOT_MINUTE;
      end else begin
         s = SLOT_SECOND;
      end
      return s;
   endfunction

endpackage

@@ hdl/srlp_char_decode.sv @@
// ----------------------------------------------------------------------------
// srlp_char_decode - character classifier
// Flags newline and gives the decimal and hex digit values of one character.
// ----------------------------------------------------------------------------
module srlp_char_decode (
   input  logic [7:0]             char_code,
   output srlp_pkg::char_info_type info
);
   import srlp_pkg::*;

   logic is_dec;
   logic is_lc;
   logic is_uc;

   // classify
   assign is_dec = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign is_lc  = (char_code >= CHAR_LC_A) && (char_code <= CHAR_LC_F);
   assign is_uc  = (char_code >= CHAR_UC_A) && (char_code <= CHAR_UC_F);

   // digit values; invalid characters read as zero
   always_comb begin
      info.newline = (char_code == CHAR_NEWLINE);
      info.dec_ok  = is_dec;
      info.dec_val = is_dec ? char_code[3:0] : 4'd0;
      info.hex_ok  = is_dec || is_lc || is_uc;
      if (is_dec) begin
         info.hex_val = char_code[3:0];
      end else if (is_lc || is_uc) begin
         info.hex_val = char_code[3:0] + HEX_LETTER_OFS;
      end else begin
         info.hex_val = 4'd0;
      end
   end

endmodule

@@ hdl/srlp_line_state.sv @@
// ----------------------------------------------------------------------------
// srlp_line_state - line position and field accumulators
// Advances one character per step, builds the year, date/time pairs and hex
// bytes, and presents the finished record at the last position of the line.
// ----------------------------------------------------------------------------
module srlp_line_state (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  srlp_pkg::char_info_type   info,
   output srlp_pkg::line_status_type status,
   output srlp_pkg::record_type      record
);
   import srlp_pkg::*;

   logic [POS_W-1:0]   pos_ff,      pos_in;
   logic [YEAR_W-1:0]  year_ff,     year_in;
   logic [PAIR_W-1:0]  pair_ff,     pair_in;
   logic [PAIR_W-1:0]  slot_ff [SLOTS];
   logic [3:0]         nib_ff,      nib_in;
   logic [7:0]         temp_hi_ff,  temp_hi_in;
   logic [7:0]         hum_hi_ff,   hum_hi_in;
   logic [BATT_W-1:0]  batt_ff,     batt_in;
   logic [TENTH_W-1:0] temp_ff,     temp_in;
   logic               err_ff,      err_in;

   pos_kind_type      kind;
   logic [7:0]        byte_val;
   logic [PAIR_W-1:0] pair_next;
   logic              slot_we;
   logic [SLOT_W-1:0] slot_idx;
   logic              end_of_line;
   logic              clear_line;

   assign kind     = pos_kind(pos_ff);
   assign byte_val = {nib_ff, info.hex_val};
   assign slot_idx = slot_of(pos_ff);
   // pair * 10 + digit, stays below 100
   assign pair_next = {pair_ff[3:0], 3'b000} + {pair_ff[5:0], 1'b0}
                      + {3'b000, info.dec_val};

   assign end_of_line = (kind == KIND_HEX_LO) && (pos_ff == POS_HUM_LO);
   assign clear_line  = info.newline || end_of_line;

   // next state of the accumulators
   always_comb begin
      pos_in     = pos_ff + 5'd1;
      year_in    = year_ff;
      pair_in    = pair_ff;
      nib_in     = nib_ff;
      temp_hi_in = temp_hi_ff;
      hum_hi_in  = hum_hi_ff;
      batt_in    = batt_ff;
      temp_in    = temp_ff;
      err_in     = err_ff;
      slot_we    = 1'b0;
      unique case (kind)
         KIND_YEAR: begin
            // year * 10 + digit
            year_in = {year_ff[10:0], 3'b000} + {year_ff[12:0], 1'b0}
                      + {10'd0, info.dec_val};
            err_in  = err_ff || !info.dec_ok;
         end
         KIND_PAIR_HI: begin
            pair_in = {3'b000, info.dec_val};
            err_in  = err_ff || !info.dec_ok;
         end
         KIND_PAIR_LO: begin
            pair_in = pair_next;
            slot_we = 1'b1;
            err_in  = err_ff || !info.dec_ok;
         end
         KIND_HEX_HI: begin
            nib_in = info.hex_val;
            err_in = err_ff || !info.hex_ok;
         end
         KIND_HEX_LO: begin
            err_in = err_ff || !info.hex_ok;
            if (pos_ff == POS_BATT_LO) begin
               // byte * 30 = byte * 32 - byte * 2
               batt_in = {byte_val, 5'b00000} - {4'b0000, byte_val, 1'b0};
            end else if (pos_ff == POS_TEMP_HI) begin
               temp_hi_in = byte_val;
            end else if (pos_ff == POS_TEMP_LO) begin
               temp_in = {temp_hi_ff, byte_val};
            end else if (pos_ff == POS_HUM_HI) begin
               hum_hi_in = byte_val;
            end
         end
         default: begin
            // separators: character not checked
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset || (step && clear_line)) begin
         pos_ff     <= '0;
         year_ff    <= '0;
         pair_ff    <= '0;
         nib_ff     <= '0;
         temp_hi_ff <= '0;
         hum_hi_ff  <= '0;
         batt_ff    <= '0;
         temp_ff    <= '0;
         err_ff     <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (step) begin
         pos_ff     <= pos_in;
         year_ff    <= year_in;
         pair_ff    <= pair_in;
         nib_ff     <= nib_in;
         temp_hi_ff <= temp_hi_in;
         hum_hi_ff  <= hum_hi_in;
         batt_ff    <= batt_in;
         temp_ff    <= temp_in;
         err_ff     <= err_in;
         if (slot_we) begin
            slot_ff[slot_idx] <= pair_next;
         end
      end
   end

   // status and the record as it would leave with this word
   always_comb begin
      status.emit     = end_of_line && !info.newline;
      status.position = pos_ff;
      record.year               = year_ff;
      record.month              = slot_ff[SLOT_MONTH];
      record.day                = slot_ff[SLOT_DAY];
      record.hour               = slot_ff[SLOT_HOUR];
      record.minute             = slot_ff[SLOT_MINUTE];
      record.second             = slot_ff[SLOT_SECOND];
      record.battery_level      = batt_ff;
      record.temperature_tenths = temp_ff;
      record.humidity_tenths    = {hum_hi_ff, byte_val};
      record.format_error       = err_in;
   end

endmodule

@@ hdl/sensor_record_line_parser_core.sv @@
// ----------------------------------------------------------------------------
// sensor_record_line_parser_core - sensor log line parser
// Parses a fixed 30-character log line, one character word at a time, into a
// record of date, time, battery, temperature and humidity.
// ----------------------------------------------------------------------------
// Takes one character word per clock cycle. Each word sits in an input
// register while the line state updates from it; the record built from the
// thirtieth character is held in a result register. Input is stalled only
// when the last character of a line arrives while the previous record is
// still waiting in the result register. A newline clears the line at any
// position and gives no record.
// ----------------------------------------------------------------------------
module sensor_record_line_parser_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_char_code,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [srlp_pkg::YEAR_W-1:0]   rsp_year,
   output logic [srlp_pkg::PAIR_W-1:0]   rsp_month,
   output logic [srlp_pkg::PAIR_W-1:0]   rsp_day,
   output logic [srlp_pkg::PAIR_W-1:0]   rsp_hour,
   output logic [srlp_pkg::PAIR_W-1:0]   rsp_minute,
   output logic [srlp_pkg::PAIR_W-1:0]   rsp_second,
   output logic [srlp_pkg::BATT_W-1:0]   rsp_battery_level,
   output logic [srlp_pkg::TENTH_W-1:0]  rsp_temperature_tenths,
   output logic [srlp_pkg::TENTH_W-1:0]  rsp_humidity_tenths,
   output logic                          rsp_format_error
);
   import srlp_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_char_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   record_type      rsp_rec_ff;
   char_info_type   info;
   line_status_type status;
   record_type      record;
   logic            advance;
   logic            load_rsp;
   logic            req_accept;

   // character decode and line state
   srlp_char_decode u_decode (
      .char_code (in_char_ff),
      .info      (info)
   );

   srlp_line_state u_state (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .info   (info),
      .status (status),
      .record (record)
   );

   // handshake: the word in hand moves on unless it needs a busy result slot
   assign advance    = in_valid_ff && (!status.emit || !rsp_valid_ff || rsp_ready);
   assign load_rsp   = advance && status.emit;
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_char_ff <= req_char_code;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_rsp) begin
         rsp_rec_ff <= record;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_year               = rsp_rec_ff.year;
   assign rsp_month              = rsp_rec_ff.month;
   assign rsp_day                = rsp_rec_ff.day;
   assign rsp_hour               = rsp_rec_ff.hour;
   assign rsp_minute             = rsp_rec_ff.minute;
   assign rsp_second             = rsp_rec_ff.second;
   assign rsp_battery_level      = rsp_rec_ff.battery_level;
   assign rsp_temperature_tenths = rsp_rec_ff.temperature_tenths;
   assign rsp_humidity_tenths    = rsp_rec_ff.humidity_tenths;
   assign rsp_format_error       = rsp_rec_ff.format_error;

   // checks
   // a word only waits when its record finds the result slot blocked
   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> (status.emit && rsp_valid_ff && !rsp_ready))
      else $error("input word stalled without a blocked record");

   // a record leaves the line at its start and is offered next cycle
   a_emit_restarts: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_valid_ff && (status.position == '0)))
      else $error("record load did not restart the line");

   // a newline word always returns the line to its start
   a_newline_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && info.newline) |=> (status.position == '0))
      else $error("newline did not restart the line");

   // position never runs past the last character of a line
   a_position_range: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> (status.position <= POS_HUM_LO))
      else $error("line position out of range");

endmodule
